// ===== src/saa_pkg.sv =====
// Package for the skyline atlas allocator: sizes, codes, config and store request types.
// Used by every module of the block except the generic RAM.
package saa_pkg;

    localparam int MAX_COLUMNS = 256;
    localparam int ADDR_W      = (MAX_COLUMNS > 1) ? $clog2(MAX_COLUMNS) : 1;
    localparam int TOP_W       = 9;
    localparam int SUM_W       = ((ADDR_W > TOP_W) ? ADDR_W : TOP_W) + 1;
    localparam int MAX_EFF     = (MAX_COLUMNS < 256) ? MAX_COLUMNS : 256;

    typedef enum logic [1:0] {
        CFG_ATLAS_WIDTH  = 2'd0,
        CFG_ATLAS_HEIGHT = 2'd1,
        CFG_COLUMN_STEP  = 2'd2
    } cfg_index_t;

    typedef enum logic [1:0] {
        ST_PLACED = 2'd0,
        ST_FRESH  = 2'd1,
        ST_REJECT = 2'd2
    } status_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_READ,
        S_CMP,
        S_DECIDE,
        S_WRITE,
        S_FINISH
    } state_t;

    typedef struct packed {
        logic [8:0] atlas_width;
        logic [8:0] atlas_height;
        logic [2:0] column_step;
    } cfg_t;

    typedef struct packed {
        logic              rd_en;
        logic              wr_en;
        logic              clear;
        logic [ADDR_W-1:0] addr;
        logic [TOP_W-1:0]  wdata;
    } sky_req_t;

    function automatic logic [8:0] eff_width(input logic [8:0] v);
        logic [8:0] r;
        r = v;
        if (r == 9'd0)
            r = 9'd1;
        if (r > 9'(MAX_EFF))
            r = 9'(MAX_EFF);
        return r;
    endfunction

    function automatic logic [8:0] eff_height(input logic [8:0] v);
        logic [8:0] r;
        r = v;
        if (r == 9'd0)
            r = 9'd1;
        if (r > 9'd256)
            r = 9'd256;
        return r;
    endfunction

    function automatic logic [2:0] eff_step(input logic [2:0] v);
        return (v == 3'd0) ? 3'd1 : v;
    endfunction

endpackage

// ===== src/saa_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module saa_ram #(
    parameter int WIDTH = 9,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
            mem[wr_addr] <= wr_data;
        if (rd_en)
            rd_data_reg <= mem[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== src/saa_skyline.sv =====
// Skyline column store: height RAM plus per-column valid bits that read as zero.
// Depends on saa_pkg and saa_ram.
module saa_skyline
    import saa_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  sky_req_t         req,
    output logic [TOP_W-1:0] rd_top
);

    logic [MAX_COLUMNS-1:0] valid_reg;
    logic [MAX_COLUMNS-1:0] valid_next;
    logic                   valid_q_reg;
    logic [TOP_W-1:0]       rd_data;

    saa_ram #(
        .WIDTH(TOP_W),
        .DEPTH(MAX_COLUMNS)
    ) u_ram (
        .clk    (clk),
        .wr_en  (req.wr_en),
        .wr_addr(req.addr),
        .wr_data(req.wdata),
        .rd_en  (req.rd_en),
        .rd_addr(req.addr),
        .rd_data(rd_data)
    );

    always_comb
    begin
        valid_next = valid_reg;
        if (req.clear)
            valid_next = '0;
        if (req.wr_en)
            valid_next[req.addr] = 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg   <= '0;
            valid_q_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
            if (req.rd_en)
                valid_q_reg <= valid_reg[req.addr];
        end
    end

    assign rd_top = valid_q_reg ? rd_data : '0;

endmodule

// ===== src/saa_seq.sv =====
// Sequencer and shared max/compare datapath: scans candidate spans, then writes a span; rejects skip both.
// Depends on saa_pkg; drives the column store through sky_req_t.
module saa_seq
    import saa_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  cfg_t             cfg,
    input  logic             in_valid,
    output logic             in_stall,
    input  logic [8:0]       rect_width,
    input  logic [8:0]       rect_height,
    output logic             out_valid,
    input  logic             out_stall,
    output logic [7:0]       place_x,
    output logic [7:0]       place_y,
    output logic [1:0]       status,
    output sky_req_t         sky_req,
    input  logic [TOP_W-1:0] rd_top
);

    state_t state_reg;
    state_t state_next;

    logic [8:0]        w_reg;
    logic [8:0]        h_reg;
    logic [8:0]        cols_reg;
    logic [8:0]        rows_reg;
    logic [2:0]        step_reg;
    logic [ADDR_W-1:0] x_reg;
    logic [8:0]        j_reg;
    logic [TOP_W-1:0]  top_reg;
    logic              found_reg;
    logic [ADDR_W-1:0] bestx_reg;
    logic [TOP_W-1:0]  besty_reg;
    logic [ADDR_W-1:0] base_reg;
    logic [TOP_W-1:0]  wval_reg;
    logic [7:0]        res_x_reg;
    logic [7:0]        res_y_reg;
    status_t           res_st_reg;
    logic              out_valid_reg;
    logic [7:0]        place_x_reg;
    logic [7:0]        place_y_reg;
    status_t           status_reg;

    logic [8:0]       cols;
    logic [8:0]       rows;
    logic             reject;
    logic             no_cand;
    logic [TOP_W-1:0] new_top;
    logic             last;
    logic             dead;
    logic [SUM_W-1:0] x_adv;
    logic             more;
    logic             fit;
    logic             out_free;
    logic [SUM_W-1:0] rd_sum;
    logic [SUM_W-1:0] wr_sum;

    assign cols     = eff_width(cfg.atlas_width);
    assign rows     = eff_height(cfg.atlas_height);
    assign reject   = (rect_width == 9'd0) || (rect_height == 9'd0)
                      || (rect_width > cols) || (rect_height > rows);
    assign no_cand  = rect_width >= cols;
    assign new_top  = (rd_top > top_reg) ? rd_top : top_reg;
    assign last     = (j_reg + 9'd1) == w_reg;
    assign dead     = found_reg && (new_top >= besty_reg);
    assign x_adv    = SUM_W'(x_reg) + SUM_W'(step_reg);
    assign more     = (x_adv + SUM_W'(w_reg)) < SUM_W'(cols_reg);
    assign fit      = found_reg
                      && ((10'(besty_reg) + 10'(h_reg)) <= 10'(rows_reg));
    assign out_free = !out_valid_reg || !out_stall;
    assign rd_sum   = SUM_W'(x_reg) + SUM_W'(j_reg);
    assign wr_sum   = SUM_W'(base_reg) + SUM_W'(j_reg);

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    if (reject)
                        state_next = S_FINISH;
                    else if (no_cand)
                        state_next = S_DECIDE;
                    else
                        state_next = S_READ;
                end
            end
            S_READ:
                state_next = S_CMP;
            S_CMP:
            begin
                if (last || dead)
                    state_next = more ? S_READ : S_DECIDE;
                else
                    state_next = S_READ;
            end
            S_DECIDE:
                state_next = S_WRITE;
            S_WRITE:
            begin
                if (last)
                    state_next = S_FINISH;
            end
            S_FINISH:
            begin
                if (out_free)
                    state_next = S_IDLE;
            end
            default:
                state_next = S_IDLE;
        endcase
    end

    always_comb
    begin
        in_stall      = 1'b1;
        sky_req.rd_en = 1'b0;
        sky_req.wr_en = 1'b0;
        sky_req.clear = 1'b0;
        sky_req.addr  = rd_sum[ADDR_W-1:0];
        sky_req.wdata = wval_reg;
        unique case (state_reg)
            S_IDLE:
                in_stall = 1'b0;
            S_READ:
                sky_req.rd_en = 1'b1;
            S_DECIDE:
                sky_req.clear = !fit;
            S_WRITE:
            begin
                sky_req.wr_en = 1'b1;
                sky_req.addr  = wr_sum[ADDR_W-1:0];
            end
            S_CMP, S_FINISH:
                in_stall = 1'b1;
            default:
                in_stall = 1'b1;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (state_reg == S_FINISH && out_free)
                out_valid_reg <= 1'b1;
            else if (!out_stall)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        case (state_reg)
            S_IDLE:
            begin
                w_reg     <= rect_width;
                h_reg     <= rect_height;
                cols_reg  <= cols;
                rows_reg  <= rows;
                step_reg  <= eff_step(cfg.column_step);
                x_reg     <= '0;
                j_reg     <= '0;
                top_reg   <= '0;
                found_reg <= 1'b0;
                res_x_reg  <= '0;
                res_y_reg  <= '0;
                res_st_reg <= ST_REJECT;
            end
            S_CMP:
            begin
                if (last || dead)
                begin
                    if (!dead)
                    begin
                        found_reg <= 1'b1;
                        bestx_reg <= x_reg;
                        besty_reg <= new_top;
                    end
                    x_reg   <= x_adv[ADDR_W-1:0];
                    j_reg   <= '0;
                    top_reg <= '0;
                end
                else
                begin
                    j_reg   <= j_reg + 9'd1;
                    top_reg <= new_top;
                end
            end
            S_DECIDE:
            begin
                j_reg <= '0;
                if (fit)
                begin
                    base_reg   <= bestx_reg;
                    wval_reg   <= TOP_W'(10'(besty_reg) + 10'(h_reg));
                    res_x_reg  <= 8'(bestx_reg);
                    res_y_reg  <= 8'(besty_reg);
                    res_st_reg <= ST_PLACED;
                end
                else
                begin
                    base_reg   <= '0;
                    wval_reg   <= h_reg;
                    res_x_reg  <= '0;
                    res_y_reg  <= '0;
                    res_st_reg <= ST_FRESH;
                end
            end
            S_WRITE:
                j_reg <= j_reg + 9'd1;
            S_FINISH:
            begin
                if (out_free)
                begin
                    place_x_reg <= res_x_reg;
                    place_y_reg <= res_y_reg;
                    status_reg  <= res_st_reg;
                end
            end
            default:
                j_reg <= j_reg;
        endcase
    end

    assign out_valid = out_valid_reg;
    assign place_x   = place_x_reg;
    assign place_y   = place_y_reg;
    assign status    = status_reg;

endmodule

// ===== src/skyline_atlas_allocator_unit.sv =====
// Skyline atlas allocator top: config registers, sequencer and skyline column store.
// The scan reads each candidate span column by column, comparing each read; a span stops
// early once its top reaches the best so far. Then the chosen or fresh span is written
// column by column; a rejected request skips both. Throughput: one request at a time;
// in_stall stays high until the result is in the output register, and the next request
// may enter while that result waits. The scan is set by the single RAM read port and the shared max/compare unit.
// Reset: asynchronous, active low; skyline cleared through per-column valid bits, no sweep.
module skyline_atlas_allocator_unit
    import saa_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       cfg_valid,
    output logic       cfg_ready,
    input  logic [1:0] cfg_index,
    input  logic [8:0] cfg_data,
    input  logic       in_valid,
    output logic       in_stall,
    input  logic [8:0] rect_width,
    input  logic [8:0] rect_height,
    output logic       out_valid,
    input  logic       out_stall,
    output logic [7:0] place_x,
    output logic [7:0] place_y,
    output logic [1:0] status
);

    cfg_t             cfg_reg;
    sky_req_t         sky_req;
    logic [TOP_W-1:0] rd_top;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.atlas_width  <= 9'd256;
            cfg_reg.atlas_height <= 9'd256;
            cfg_reg.column_step  <= 3'd1;
        end
        else if (cfg_valid && cfg_ready)
        begin
            if (cfg_index == CFG_ATLAS_WIDTH)
                cfg_reg.atlas_width <= cfg_data;
            else if (cfg_index == CFG_ATLAS_HEIGHT)
                cfg_reg.atlas_height <= cfg_data;
            else if (cfg_index == CFG_COLUMN_STEP)
                cfg_reg.column_step <= cfg_data[2:0];
        end
    end

    saa_seq u_seq (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg_reg),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .rect_width (rect_width),
        .rect_height(rect_height),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .place_x    (place_x),
        .place_y    (place_y),
        .status     (status),
        .sky_req    (sky_req),
        .rd_top     (rd_top)
    );

    saa_skyline u_skyline (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (sky_req),
        .rd_top(rd_top)
    );

`ifndef NO_ASSERTIONS
    a_busy_after_transfer: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall |=> in_stall)
        else $error("input taken while a request is in progress");

    a_origin_on_fresh: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (status == ST_FRESH || status == ST_REJECT)
        |-> place_x == 8'd0 && place_y == 8'd0)
        else $error("fresh or rejected result not at origin");

    a_no_rw_overlap: assert property (@(posedge clk) disable iff (!rst_n)
        !(sky_req.rd_en && (sky_req.wr_en || sky_req.clear)))
        else $error("skyline read overlaps a write or clear");
`endif

endmodule
